FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define AST_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true
`define AST_NEVER(label, expr, msg) \
  `AST_CHK(label, !(expr), msg)

`endif

FILE: sv/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Types and constants of the tween slot engine.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int VALUE_BITS = 16;
  localparam int FRAME_BITS = 16;
  localparam logic [16:0] Q_ONE = 17'd32768;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_TICK   = 2'd1,
    OP_DELETE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOSLOT = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam logic [1:0] EASE_IN     = 2'd0;
  localparam logic [1:0] EASE_LINEAR = 2'd3;

  // one slot record as held in the slot memory
  typedef struct packed {
    logic [FRAME_BITS-1:0]        fc;
    logic [FRAME_BITS-1:0]        start_f;
    logic signed [FRAME_BITS:0]   end_f;
    logic signed [VALUE_BITS-1:0] from_v;
    logic signed [VALUE_BITS-1:0] to_v;
    logic [1:0]                   ease;
    logic signed [VALUE_BITS-1:0] cur;
  } slot_rec_t;

endpackage

FILE: sv/tween_slot_engine.sv
// ----------------------------------------------------------------------------
// tween_slot_engine
// Table of animation slots, each tweening one value between two keyframes.
// ----------------------------------------------------------------------------
// Create and unused-slot results go from S_IDLE straight to S_EMIT; delete and
//   query of a used slot first read the slot through S_RD and S_EVAL.
// Tick: walks every slot in order through the slot memory; an alive slot is read,
//   updated and written back, passing a 16-step serial divider, two squares and
//   one multiply when it interpolates; free slots are skipped and stopped slots
//   only reported, and output stalls can hold the walk.
// One item at a time; rst clears used/alive bits, the sequencer and m_tvalid.
module tween_slot_engine #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot[3:0], first_frame[19:4], last_frame[36:20], from_value[52:37],
  // to_value[68:53], ease_mode[70:69], pad[71]
  input  logic [71:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_slot[3:0], value[19:4], finished[20], running[21], pad[23:22]
  output logic [23:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import tse_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EVAL, S_DIV, S_SQ1, S_SQ2, S_MUL, S_FIN, S_WB, S_EMIT
  } state_t;

  state_t state;
  logic [SLOTS-1:0] in_use;
  logic [SLOTS-1:0] alive;
  slot_rec_t mem [SLOTS];
  slot_rec_t rd_data;
  slot_rec_t rec;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] idx;
  op_t op;

  logic wr_en;
  logic [SW-1:0] wr_addr;
  slot_rec_t wr_data;

  logic [FRAME_BITS-1:0] fc_new;
  logic signed [VALUE_BITS-1:0] cur_new;
  logic alive_new;

  logic [FRAME_BITS+1:0] div_r;
  logic [FRAME_BITS:0]   div_d;
  logic [15:0]           div_q;
  logic [3:0]            div_cnt;
  logic [16:0]           sq1;
  logic [16:0]           sq2;
  logic signed [35:0]    prod;

  logic [3:0]                   res_slot;
  logic signed [VALUE_BITS-1:0] res_value;
  logic res_fin, res_run, res_last;
  status_t res_status;

  // input fields
  logic [3:0]                   in_slot;
  logic [FRAME_BITS-1:0]        in_first;
  logic signed [FRAME_BITS:0]   in_last_f;
  logic signed [VALUE_BITS-1:0] in_from;
  logic signed [VALUE_BITS-1:0] in_to;
  logic [1:0]                   in_ease;

  assign in_slot   = s_tdata[3:0];
  assign in_first  = s_tdata[19:4];
  assign in_last_f = s_tdata[36:20];
  assign in_from   = s_tdata[52:37];
  assign in_to     = s_tdata[68:53];
  assign in_ease   = s_tdata[70:69];

  assign s_tready = (state == S_IDLE);

  logic accept;
  assign accept = s_tvalid && s_tready;

  // output register loads a new item
  logic emit_go;
  assign emit_go = (state == S_EMIT) && (!m_tvalid || m_tready);

  // lowest free slot
  logic [SW-1:0] free_idx;
  logic          any_free;
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!in_use[j]) begin
        free_idx = SW'(j);
        any_free = 1'b1;
      end
    end
  end

  // used slot beyond the current one
  logic later_used;
  always_comb begin
    later_used = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (in_use[j] && (j > int'(idx))) later_used = 1'b1;
    end
  end

  logic [6:0] slot_ext;
  logic       slot_ok;
  assign slot_ext = {3'b000, in_slot};
  assign slot_ok  = (int'(slot_ext) < SLOTS) && in_use[slot_ext[SW-1:0]];

  logic [6:0] idx_ext;
  assign idx_ext = 7'(idx);

  // record fields in signed compare range
  logic signed [FRAME_BITS+1:0] end_s, start_s, den_s, num_s, fcn_s;
  assign end_s   = {rd_data.end_f[FRAME_BITS], rd_data.end_f};
  assign start_s = {2'b00, rd_data.start_f};
  assign den_s   = end_s - start_s;

  logic [FRAME_BITS:0] next_u;
  assign next_u = {1'b0, rd_data.fc} + 17'd1;
  assign num_s  = end_s - $signed({1'b0, next_u});
  assign fcn_s  = $signed({2'b00, fc_new});

  logic [FRAME_BITS+1:0] div_sub;
  logic                  div_ge;
  assign div_ge  = (div_r >= {1'b0, div_d});
  assign div_sub = div_ge ? (div_r - {1'b0, div_d}) : div_r;

  logic [16:0] sq_in;
  logic [33:0] sq_prod;
  assign sq_in   = (state == S_SQ1) ?
                   ((rec.ease == EASE_IN) ? (Q_ONE - {1'b0, div_q}) : {1'b0, div_q}) : sq1;
  assign sq_prod = sq_in * sq_in + 34'd16384;

  logic [16:0] ease_e;
  always_comb begin
    priority if (rec.ease == EASE_LINEAR) ease_e = {1'b0, div_q};
    else if (rec.ease == EASE_IN) ease_e = Q_ONE - sq2;
    else ease_e = sq2;
  end

  logic signed [VALUE_BITS:0] vdiff;
  assign vdiff = {rec.from_v[VALUE_BITS-1], rec.from_v} - {rec.to_v[VALUE_BITS-1], rec.to_v};

  logic signed [35:0] p_shift;
  assign p_shift = prod >>> 15;

  // slot memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_idx;
    wr_data = rec;
    if (state == S_IDLE) begin
      wr_en = accept && (op_t'(s_tuser) == OP_CREATE) && any_free;
      wr_data.fc      = '0;
      wr_data.start_f = in_first;
      wr_data.end_f   = in_last_f;
      wr_data.from_v  = in_from;
      wr_data.to_v    = in_to;
      wr_data.ease    = in_ease;
      wr_data.cur     = in_from;
    end else if (state == S_WB) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data.fc  = fc_new;
      wr_data.cur = cur_new;
    end
  end

  // accesses are sequenced: read data is never used while the same slot is being written
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_use   <= '0;
      alive    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_go) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= op_t'(s_tuser);
            res_last   <= 1'b1;
            res_status <= ST_OK;
            unique case (op_t'(s_tuser))
              OP_CREATE: begin
                if (any_free) begin
                  in_use[free_idx] <= 1'b1;
                  alive[free_idx]  <= 1'b1;
                  res_slot  <= 4'(7'(free_idx));
                  res_value <= in_from;
                  res_fin   <= in_last_f[FRAME_BITS] || (in_last_f == '0);
                  res_run   <= 1'b1;
                end else begin
                  res_slot   <= '0;
                  res_value  <= '0;
                  res_fin    <= 1'b0;
                  res_run    <= 1'b0;
                  res_status <= ST_FULL;
                end
                state <= S_EMIT;
              end
              OP_TICK: begin
                idx     <= '0;
                rd_addr <= '0;
                state   <= S_RD;
              end
              OP_DELETE, OP_QUERY: begin
                if (slot_ok) begin
                  idx     <= slot_ext[SW-1:0];
                  rd_addr <= slot_ext[SW-1:0];
                  state   <= S_RD;
                end else begin
                  res_slot   <= in_slot;
                  res_value  <= '0;
                  res_fin    <= 1'b0;
                  res_run    <= 1'b0;
                  res_status <= ST_NOSLOT;
                  state      <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          rec       <= rd_data;
          res_slot  <= idx_ext[3:0];
          res_value <= rd_data.cur;
          res_fin   <= $signed({2'b00, rd_data.fc}) >= end_s;
          res_status <= ST_OK;
          if (op != OP_TICK) begin
            res_last <= 1'b1;
            if (op == OP_DELETE) begin
              in_use[idx] <= 1'b0;
              alive[idx]  <= 1'b0;
              res_run     <= 1'b0;
            end else begin
              res_run <= alive[idx];
            end
            state <= S_EMIT;
          end else if (!in_use[idx]) begin
            if (idx == SW'(SLOTS - 1)) begin
              state <= S_IDLE;
            end else begin
              idx     <= idx + 1'b1;
              rd_addr <= idx + 1'b1;
              state   <= S_RD;
            end
          end else if (!alive[idx]) begin
            res_run  <= 1'b0;
            res_last <= !later_used;
            state    <= S_EMIT;
          end else begin
            fc_new    <= next_u[FRAME_BITS] ? '1 : next_u[FRAME_BITS-1:0];
            alive_new <= 1'b1;
            cur_new   <= rd_data.to_v;
            state     <= S_WB;
            priority if (rd_data.end_f == '1) begin
              cur_new <= rd_data.cur;  // count only
            end else if ($signed({1'b0, next_u}) < start_s) begin
              cur_new <= rd_data.from_v;
            end else if ($signed({1'b0, next_u}) > end_s) begin
              alive_new <= 1'b0;
            end else if ((den_s <= 0) || (num_s <= 0)) begin
              cur_new <= rd_data.to_v;
            end else begin
              div_r   <= num_s[FRAME_BITS+1:0];
              div_d   <= den_s[FRAME_BITS:0];
              div_q   <= '0;
              div_cnt <= '0;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_q   <= {div_q[14:0], div_ge};
          div_r   <= {div_sub[FRAME_BITS:0], 1'b0};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) state <= S_SQ1;
        end
        S_SQ1: begin
          sq1   <= sq_prod[31:15];
          state <= S_SQ2;
        end
        S_SQ2: begin
          sq2   <= sq_prod[31:15];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 36'(vdiff) * 36'($signed({1'b0, ease_e})) + 36'sd16384;
          state <= S_FIN;
        end
        S_FIN: begin
          cur_new <= VALUE_BITS'(36'(rec.to_v) + p_shift);
          state   <= S_WB;
        end
        S_WB: begin
          alive[idx] <= alive_new;
          res_value  <= cur_new;
          res_fin    <= fcn_s >= $signed({rec.end_f[FRAME_BITS], rec.end_f});
          res_run    <= alive_new;
          res_last   <= !later_used;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            m_tdata  <= {2'b00, res_run, res_fin, res_value, res_slot};
            m_tuser  <= res_status;
            m_tlast  <= res_last;
            if ((op == OP_TICK) && (idx != SW'(SLOTS - 1))) begin
              idx     <= idx + 1'b1;
              rd_addr <= idx + 1'b1;
              state   <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `AST_NEVER(a_alive_free, (alive & ~in_use) != '0, "alive slot not in use")
  `AST_NEVER(a_div_wr, (state == S_DIV) && wr_en, "memory write during divide")
  `AST_CHK(a_create_fill, accept && (op_t'(s_tuser) == OP_CREATE) && any_free |=> $countones(in_use) == $past($countones(in_use)) + 1, "create did not take a slot")
  `AST_CHK(a_tick_last, (state == S_EMIT) && (op == OP_TICK) && (idx == SW'(SLOTS - 1)) |-> res_last, "final tick result not marked")

endmodule
